// ===== rtl/core/dcor_pkg.sv =====
// ----------------------------------------------------------------------------
// DC offset removal package
// Widths, reset values and parameter defaults shared by the DC offset
// removal block and its submodules.
// ----------------------------------------------------------------------------
package dcor_pkg;

   localparam int SAMPLE_W = 16;   // audio sample and corrected output
   localparam int EST_W    = 16;   // estimation length register
   localparam int COUNT_W  = 17;   // samples counted toward the mean
   localparam int SUM_W    = 34;   // exact signed running sum

   localparam logic [EST_W-1:0] EST_LEN_RESET = 16'd48000;

   localparam int MAX_SEGMENT_DEFAULT = 64;
   localparam int FRAC_BITS_DEFAULT   = 8;

endpackage

// ===== rtl/core/dc_offset_removal_unit.sv =====
// ----------------------------------------------------------------------------
// DC offset removal unit
// Removes the DC offset of an audio stream using the mean of its first
// samples, estimated over whole segments.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: one sample each, tlast on the last sample of a
// segment, tuser set to restart the mean estimate before that sample.
// A segment also closes on its MAX_SEGMENT-th sample. Corrected samples
// leave on rsp_* in order, with tlast on the last one of the segment.
// csr_wr_en writes estimation_length; write it only while the unit is idle.
// Sequence: a sample that does not close a segment is only stored. A closing
// sample of a segment of n samples starts a sequence of a check state, then,
// while the mean still updates, a sum of the n samples over the buffer's one
// read port and a division in the bit-serial divider, and then the emission
// of the n samples, each a registered buffer read and then an output load.
// req_tready is low during the whole sequence. A stalled receiver holds the
// output register and so the emission. Reset clears the estimator, the
// fill count and the output valid; buffer contents are left as they are.
// ----------------------------------------------------------------------------
module dc_offset_removal_unit #(
   parameter int MAX_SEGMENT = dcor_pkg::MAX_SEGMENT_DEFAULT,
   parameter int FRAC_BITS   = dcor_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [dcor_pkg::EST_W-1:0]    csr_wr_data,   // estimation_length
   // requests
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dcor_pkg::SAMPLE_W-1:0] req_tdata,     // [15:0] sample
   input  logic                          req_tlast,     // segment_end
   input  logic                          req_tuser,     // stream_start
   // results
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dcor_pkg::SAMPLE_W-1:0] rsp_tdata,     // [15:0] corrected
   output logic                          rsp_tlast      // last_of_segment
);

   localparam int SAMPLE_W = dcor_pkg::SAMPLE_W;
   localparam int SUM_W    = dcor_pkg::SUM_W;
   localparam int COUNT_W  = dcor_pkg::COUNT_W;
   localparam int ADDR_W   = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1;
   localparam int FILL_W   = $clog2(MAX_SEGMENT + 1);
   localparam int MEAN_W   = SAMPLE_W + FRAC_BITS + 1;
   localparam int NUM_W    = SUM_W + FRAC_BITS + 1;
   localparam int DEN_W    = COUNT_W + 1;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CHECK     = 3'd1;
   localparam logic [2:0] ST_SUM_RD    = 3'd2;
   localparam logic [2:0] ST_SUM_ADD   = 3'd3;
   localparam logic [2:0] ST_DIV_START = 3'd4;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd5;
   localparam logic [2:0] ST_EMIT_RD   = 3'd6;
   localparam logic [2:0] ST_EMIT_LOAD = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [dcor_pkg::EST_W-1:0]  est_ff, est_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [FILL_W-1:0]           n_ff, n_in;
   logic [ADDR_W-1:0]           idx_ff, idx_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [COUNT_W-1:0]          seen_ff, seen_in;
   logic signed [MEAN_W-1:0]    mean_ff, mean_in;
   logic [SAMPLE_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        req_accept;
   logic [FILL_W-1:0]           fill_next;
   logic                        idx_last;
   logic [SAMPLE_W-1:0]         rd_data;
   logic [SAMPLE_W-1:0]         corrected;
   logic                        out_free;
   logic [SUM_W-1:0]            sum_mag;
   logic [NUM_W-1:0]            div_dividend;
   logic [DEN_W-1:0]            div_divisor;
   logic                        div_start;
   logic                        div_done;
   logic [NUM_W-1:0]            div_quotient;
   logic [MEAN_W-1:0]           quo_trunc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign fill_next  = fill_ff + FILL_W'(1);
   assign idx_last   = (FILL_W'(idx_ff) + FILL_W'(1)) == n_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Rounding is half away from zero, so the divider works on the magnitude:
   // q = (2 * |sum| * 2^FRAC_BITS + seen) / (2 * seen).
   assign sum_mag      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_dividend = {sum_mag, {(FRAC_BITS + 1){1'b0}}} + NUM_W'(seen_ff);
   assign div_divisor  = {seen_ff, 1'b0};
   assign quo_trunc    = div_quotient[MEAN_W-1:0];

   dcor_buffer #(
      .DEPTH  (MAX_SEGMENT),
      .ADDR_W (ADDR_W)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   dcor_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   dcor_correct #(
      .FRAC_BITS (FRAC_BITS),
      .MEAN_W    (MEAN_W)
   ) u_correct (
      .sample    (rd_data),
      .mean      (mean_ff),
      .corrected (corrected)
   );

   always_comb begin
      state_in    = state_ff;
      est_in      = csr_wr_en ? csr_wr_data : est_ff;
      fill_in     = fill_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      seen_in     = seen_ff;
      mean_in     = mean_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      div_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser) begin
                  sum_in  = '0;
                  seen_in = '0;
                  mean_in = '0;
               end
               fill_in = fill_next;
               if (req_tlast || fill_next == FILL_W'(MAX_SEGMENT)) begin
                  n_in     = fill_next;
                  fill_in  = '0;
                  idx_in   = '0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (seen_ff < COUNT_W'(est_ff)) begin
               state_in = ST_SUM_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_ADD;
         end
         ST_SUM_ADD: begin
            sum_in = sum_ff + SUM_W'($signed(rd_data));
            if (idx_last) begin
               seen_in  = seen_ff + COUNT_W'(n_ff);
               idx_in   = '0;
               state_in = ST_DIV_START;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_SUM_RD;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               mean_in  = sum_ff[SUM_W-1] ? -quo_trunc : quo_trunc;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (out_free) begin
               rsp_data_in  = corrected;
               rsp_last_in  = idx_last;
               rsp_valid_in = 1'b1;
               if (idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         est_ff       <= dcor_pkg::EST_LEN_RESET;
         fill_ff      <= '0;
         n_ff         <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         seen_ff      <= '0;
         mean_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         est_ff       <= est_in;
         fill_ff      <= fill_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         mean_ff      <= mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The buffer never holds a full segment while requests are taken.
   a_fill_below_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < FILL_W'(MAX_SEGMENT)))
      else $error("fill count reached the segment size while idle");

   // A request that ends a segment always starts the close sequence.
   a_close_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (state_ff == ST_CHECK))
      else $error("segment end did not start the close sequence");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside of the wait state");

   // A new result is only loaded when the previous one has been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_data_ff) && rsp_valid_ff))
      else $error("pending result was overwritten");

endmodule

// ===== rtl/core/dcor_buffer.sv =====
// ----------------------------------------------------------------------------
// Segment buffer
// Single write port, single read port sample memory with a registered read.
// ----------------------------------------------------------------------------
module dcor_buffer #(
   parameter int DEPTH  = dcor_pkg::MAX_SEGMENT_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [dcor_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [dcor_pkg::SAMPLE_W-1:0] rd_data
);

   logic [dcor_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [dcor_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dcor_divider.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle. done pulses for one cycle
// when the quotient is final.
// ----------------------------------------------------------------------------
module dcor_divider #(
   parameter int NUM_W = 43,
   parameter int DEN_W = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         // The dividend shifts out at the top while quotient bits enter below.
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/dcor_correct.sv =====
// ----------------------------------------------------------------------------
// Sample correction
// Subtracts the fixed-point mean from one sample, clips to the 16-bit range
// and rounds to an integer with ties away from zero.
// ----------------------------------------------------------------------------
module dcor_correct #(
   parameter int FRAC_BITS = dcor_pkg::FRAC_BITS_DEFAULT,
   parameter int MEAN_W    = dcor_pkg::SAMPLE_W + FRAC_BITS + 1
) (
   input  logic signed [dcor_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [MEAN_W-1:0]             mean,
   output logic signed [dcor_pkg::SAMPLE_W-1:0] corrected
);

   localparam int D_W = dcor_pkg::SAMPLE_W + FRAC_BITS + 2;
   localparam logic signed [D_W-1:0] CLIP_HI =
      D_W'((2 ** (dcor_pkg::SAMPLE_W - 1) - 1) * 2 ** FRAC_BITS);
   localparam logic signed [D_W-1:0] CLIP_LO =
      D_W'(-(2 ** (dcor_pkg::SAMPLE_W - 1)) * 2 ** FRAC_BITS);
   localparam logic [D_W-1:0] HALF = D_W'((2 ** FRAC_BITS) / 2);

   logic signed [D_W-1:0]             diff;
   logic signed [D_W-1:0]             clipped;
   logic                              neg;
   logic [D_W-1:0]                    mag;
   logic [D_W-1:0]                    rounded;
   logic [dcor_pkg::SAMPLE_W-1:0]     int_mag;

   always_comb begin
      diff = (D_W'(sample) <<< FRAC_BITS) - D_W'(mean);
      if (diff < CLIP_LO) begin
         clipped = CLIP_LO;
      end else if (diff > CLIP_HI) begin
         clipped = CLIP_HI;
      end else begin
         clipped = diff;
      end
      neg       = clipped[D_W-1];
      mag       = neg ? D_W'(-clipped) : D_W'(clipped);
      rounded   = (mag + HALF) >> FRAC_BITS;
      int_mag   = rounded[dcor_pkg::SAMPLE_W-1:0];
      corrected = neg ? -int_mag : int_mag;
   end

endmodule
